// ===== rtl/cpm_pkg.sv =====
// Shared types, widths and codes for the contact prediction matcher.
// No dependencies; the RTL files that use it refer to it by scoped names, the bench imports it.
`timescale 1ns / 1ps

package cpm_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int TIME_W    = 64;
    localparam int LEN_W     = 32;
    localparam int PROB_W    = 16;
    localparam int MATCH_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int ENTRY_W   = TIME_W + LEN_W + PROB_W;
    localparam int DIV_CNT_W = $clog2(FRAC_W);

    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 24;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [MATCH_W-1:0] Q16_ONE          = 17'd65536;
    localparam logic [MATCH_W-1:0] EARLY_STOP_LIMIT = 17'd66;
    localparam logic [PROB_W-1:0]  MIN_PROB_RESET   = 16'd32768;
    localparam logic [MATCH_W-1:0] MIN_MATCH_RESET  = 17'd52429;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_VALIDATE = 1'b1;

    localparam logic REG_MIN_PROB  = 1'b0;
    localparam logic REG_MIN_MATCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MATCH,
        ST_FINISH
    } cpm_state_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_SPAN,
        M_RANGE,
        M_DIV,
        M_DONE
    } match_state_t;

    typedef struct packed {
        logic               done;
        logic               future;
        logic [MATCH_W-1:0] value;
    } match_status_t;

endpackage

// ===== rtl/cpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cpm_frac_div.sv =====
// Bit-serial restoring divider: floor((num << 16) / den) for num < den.
// Depends on cpm_pkg for widths.
`timescale 1ns / 1ps

module cpm_frac_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cpm_pkg::LEN_W-1:0]  num,
    input  logic [cpm_pkg::LEN_W-1:0]  den,
    output logic                       done,
    output logic [cpm_pkg::FRAC_W-1:0] quotient
);

    logic [cpm_pkg::LEN_W-1:0]     rem_reg, rem_next;
    logic [cpm_pkg::LEN_W-1:0]     den_reg, den_next;
    logic [cpm_pkg::FRAC_W-1:0]    quo_reg, quo_next;
    logic [cpm_pkg::DIV_CNT_W-1:0] step_reg, step_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [cpm_pkg::LEN_W:0]       shifted;
    logic [cpm_pkg::LEN_W:0]       diff;
    logic                          ge;

    // remainder stays below den, so the doubled value fits one extra bit
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            quo_next  = '0;
            step_next = cpm_pkg::DIV_CNT_W'(cpm_pkg::FRAC_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[cpm_pkg::LEN_W-1:0] : shifted[cpm_pkg::LEN_W-1:0];
            quo_next  = {quo_reg[cpm_pkg::FRAC_W-2:0], ge};
            step_next = step_reg - cpm_pkg::DIV_CNT_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/cpm_match.sv =====
// Time match of one stored window against the query time, Q16 result.
// Depends on cpm_pkg and cpm_frac_div.
`timescale 1ns / 1ps

module cpm_match (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cpm_pkg::TIME_W-1:0] win_start,
    input  logic [cpm_pkg::LEN_W-1:0]  win_length,
    input  logic [cpm_pkg::TIME_W-1:0] query_time,
    output cpm_pkg::match_status_t     status
);

    cpm_pkg::match_state_t state_reg, state_next;

    logic [cpm_pkg::TIME_W-1:0]  we_reg, we_next;
    logic [cpm_pkg::LEN_W-1:0]   dur_reg, dur_next;
    logic                        future_reg, future_next;
    logic [cpm_pkg::TIME_W-1:0]  d_reg, d_next;
    logic [cpm_pkg::MATCH_W-1:0] value_reg, value_next;
    logic [cpm_pkg::TIME_W:0]    sum;
    logic [cpm_pkg::TIME_W-1:0]  sub_a, sub_b;
    logic                        div_start;
    logic [cpm_pkg::LEN_W-1:0]   div_num;
    logic                        div_done;
    logic [cpm_pkg::FRAC_W-1:0]  div_quo;

    assign sum     = {1'b0, win_start} + {33'b0, win_length};
    assign sub_a   = future_reg ? win_start : query_time;
    assign sub_b   = future_reg ? query_time : we_reg;
    assign div_num = dur_reg - d_reg[cpm_pkg::LEN_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        we_next     = we_reg;
        dur_next    = dur_reg;
        future_next = future_reg;
        d_next      = d_reg;
        value_next  = value_reg;
        div_start   = 1'b0;
        case (state_reg)
            cpm_pkg::M_IDLE:
            begin
                if (start)
                begin
                    // saturate the window end; the span then never exceeds 32 bits
                    we_next     = sum[cpm_pkg::TIME_W] ? '1 : sum[cpm_pkg::TIME_W-1:0];
                    dur_next    = sum[cpm_pkg::TIME_W] ? ~win_start[cpm_pkg::LEN_W-1:0]
                                                       : win_length;
                    future_next = win_start > query_time;
                    state_next  = cpm_pkg::M_SPAN;
                end
            end
            cpm_pkg::M_SPAN:
            begin
                if (dur_reg == '0)
                begin
                    value_next = '0;
                    state_next = cpm_pkg::M_DONE;
                end
                else if (!future_reg && query_time <= we_reg)
                begin
                    value_next = cpm_pkg::Q16_ONE;
                    state_next = cpm_pkg::M_DONE;
                end
                else
                begin
                    d_next     = sub_a - sub_b;
                    state_next = cpm_pkg::M_RANGE;
                end
            end
            cpm_pkg::M_RANGE:
            begin
                if (d_reg[cpm_pkg::TIME_W-1:cpm_pkg::LEN_W] != '0 ||
                    d_reg[cpm_pkg::LEN_W-1:0] >= dur_reg)
                begin
                    value_next = '0;
                    state_next = cpm_pkg::M_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = cpm_pkg::M_DIV;
                end
            end
            cpm_pkg::M_DIV:
            begin
                if (div_done)
                begin
                    value_next = {1'b0, div_quo};
                    state_next = cpm_pkg::M_DONE;
                end
            end
            cpm_pkg::M_DONE:
            begin
                state_next = cpm_pkg::M_IDLE;
            end
            default:
            begin
                state_next = cpm_pkg::M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpm_pkg::M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        we_reg     <= we_next;
        dur_reg    <= dur_next;
        future_reg <= future_next;
        d_reg      <= d_next;
        value_reg  <= value_next;
    end

    cpm_frac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (dur_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign status.done   = (state_reg == cpm_pkg::M_DONE);
    assign status.future = future_reg;
    assign status.value  = value_reg;

endmodule

// ===== rtl/contact_prediction_matcher.sv =====
// Top level of the contact prediction matcher: stream ports, APB registers, walk control.
// Depends on cpm_pkg, cpm_ram, cpm_match (and through it cpm_frac_div).
//
// Usage:
//   Input words arrive on s_axis_*; tuser carries the command (load or validate).
//   A load writes one window into the ring and returns an all-zero result word.
//   A validate walks up to slot_count (at most ENTRIES) ring entries from slot, wrapping at ENTRIES, and
//   returns one result word on m_axis_* (success, found flag, slot, Q16 match).
//   Each entry is read from RAM and is either skipped on probability or examined
//   (window span, distance, range check, then the 16-step bit-serial divider).
//   One word is in the block at a time; s_axis_tready is high only when idle.
//   The result sits in an output register, so the next word is taken while the
//   last result still waits; a stalled m_axis_tready holds the walk at its end.
//   Reset clears control and loads the register defaults (min_probability 32768,
//   min_match 52429); ring contents are undefined until loaded.
//   Registers via APB: 0x0 min_probability, 0x4 min_match; pready is always high.
`timescale 1ns / 1ps

module contact_prediction_matcher #(
    parameter int ENTRIES = cpm_pkg::ENTRIES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot[3:0], slot_count[8:4], query_time[72:9], window_start[136:73],
    // window_length[168:137], window_probability[184:169], elevation_ok[185]
    input  logic [cpm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // success[0], prediction_found[1], matched_slot[5:2], match_value[22:6]
    output logic [cpm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cpm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cpm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cpm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_MAX = (ENTRIES < 31) ? ENTRIES : 31;
    localparam logic [8:0] ENT9 = 9'(ENTRIES);

    cpm_pkg::cpm_state_t state_reg, state_next;

    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic [cpm_pkg::COUNT_W-1:0]       cnt_reg, cnt_next;
    logic [cpm_pkg::TIME_W-1:0]        t_reg, t_next;
    logic                              elev_reg, elev_next;
    logic                              found_reg, found_next;
    logic [cpm_pkg::SLOT_W-1:0]        mslot_reg, mslot_next;
    logic [cpm_pkg::MATCH_W-1:0]       mval_reg, mval_next;
    logic                              m_valid_reg, m_valid_next;
    logic [cpm_pkg::OUT_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic [cpm_pkg::PROB_W-1:0]        min_prob_reg;
    logic [cpm_pkg::MATCH_W-1:0]       min_match_reg;

    logic [cpm_pkg::SLOT_W-1:0]        in_slot;
    logic [cpm_pkg::COUNT_W-1:0]       in_count;
    logic [cpm_pkg::COUNT_W-1:0]       count_sat;
    logic [8:0]                        slot_wrap;
    logic [IDX_W-1:0]                  slot_idx;
    logic [IDX_W-1:0]                  idx_inc;
    logic                              s_ready;
    logic                              ram_we;
    logic                              ram_re;
    logic [cpm_pkg::ENTRY_W-1:0]       ram_wdata;
    logic [cpm_pkg::ENTRY_W-1:0]       ram_rdata;
    logic [cpm_pkg::TIME_W-1:0]        rd_start;
    logic [cpm_pkg::LEN_W-1:0]         rd_length;
    logic [cpm_pkg::PROB_W-1:0]        rd_prob;
    logic                              match_start;
    logic                              out_load;
    logic                              cfg_wr;
    cpm_pkg::match_status_t            mstat;

    assign in_slot   = s_axis_tdata[3:0];
    assign in_count  = s_axis_tdata[8:4];
    assign count_sat = (in_count > cpm_pkg::COUNT_W'(CNT_MAX)) ?
                       cpm_pkg::COUNT_W'(CNT_MAX) : in_count;
    // entry order in RAM: start low, then length, then probability
    assign ram_wdata = s_axis_tdata[184:73];
    assign rd_start  = ram_rdata[cpm_pkg::TIME_W-1:0];
    assign rd_length = ram_rdata[cpm_pkg::TIME_W +: cpm_pkg::LEN_W];
    assign rd_prob   = ram_rdata[cpm_pkg::ENTRY_W-1 -: cpm_pkg::PROB_W];

    // fold the 4-bit slot into the ring; at most seven subtractions
    always_comb
    begin
        slot_wrap = {5'b0, in_slot};
        for (int i = 0; i < 8; i++)
        begin
            if (slot_wrap >= ENT9)
            begin
                slot_wrap = slot_wrap - ENT9;
            end
        end
    end

    assign slot_idx = slot_wrap[IDX_W-1:0];
    assign idx_inc  = (idx_reg == IDX_W'(ENTRIES - 1)) ? '0 : idx_reg + IDX_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        t_next      = t_reg;
        elev_next   = elev_reg;
        found_next  = found_reg;
        mslot_next  = mslot_reg;
        mval_next   = mval_reg;
        s_ready     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        match_start = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            cpm_pkg::ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_axis_tvalid)
                begin
                    found_next = 1'b0;
                    mslot_next = '0;
                    mval_next  = '0;
                    if (s_axis_tuser == cpm_pkg::CMD_LOAD)
                    begin
                        ram_we     = 1'b1;
                        elev_next  = 1'b0;
                        state_next = cpm_pkg::ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = slot_idx;
                        cnt_next   = count_sat;
                        t_next     = s_axis_tdata[72:9];
                        elev_next  = s_axis_tdata[185];
                        state_next = (count_sat == '0) ? cpm_pkg::ST_FINISH
                                                       : cpm_pkg::ST_READ;
                    end
                end
            end
            cpm_pkg::ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = cpm_pkg::ST_CHECK;
            end
            cpm_pkg::ST_CHECK:
            begin
                if (rd_prob < min_prob_reg)
                begin
                    // skip this entry
                    cnt_next   = cnt_reg - cpm_pkg::COUNT_W'(1);
                    idx_next   = idx_inc;
                    state_next = (cnt_reg == cpm_pkg::COUNT_W'(1)) ? cpm_pkg::ST_FINISH
                                                                   : cpm_pkg::ST_READ;
                end
                else
                begin
                    match_start = 1'b1;
                    state_next  = cpm_pkg::ST_MATCH;
                end
            end
            cpm_pkg::ST_MATCH:
            begin
                if (mstat.done)
                begin
                    if (mstat.value > min_match_reg)
                    begin
                        found_next = 1'b1;
                        mslot_next = cpm_pkg::SLOT_W'(idx_reg);
                        mval_next  = mstat.value;
                        state_next = cpm_pkg::ST_FINISH;
                    end
                    else if (mstat.future && mstat.value < cpm_pkg::EARLY_STOP_LIMIT)
                    begin
                        // later windows lie further out: drop the rest of the walk
                        state_next = cpm_pkg::ST_FINISH;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - cpm_pkg::COUNT_W'(1);
                        idx_next   = idx_inc;
                        state_next = (cnt_reg == cpm_pkg::COUNT_W'(1)) ?
                                     cpm_pkg::ST_FINISH : cpm_pkg::ST_READ;
                    end
                end
            end
            cpm_pkg::ST_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = cpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, mval_reg, mslot_reg, found_reg, found_reg | elev_reg};
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cpm_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        t_reg      <= t_next;
        elev_reg   <= elev_next;
        found_reg  <= found_next;
        mslot_reg  <= mslot_next;
        mval_reg   <= mval_next;
        m_data_reg <= m_data_next;
    end

    // configuration registers; address bit 2 selects the register
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_prob_reg  <= cpm_pkg::MIN_PROB_RESET;
            min_match_reg <= cpm_pkg::MIN_MATCH_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == cpm_pkg::REG_MIN_PROB)
            begin
                min_prob_reg <= pwdata[cpm_pkg::PROB_W-1:0];
            end
            else
            begin
                min_match_reg <= pwdata[cpm_pkg::MATCH_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == cpm_pkg::REG_MIN_PROB) ?
                    cpm_pkg::APB_DATA_W'(min_prob_reg) :
                    cpm_pkg::APB_DATA_W'(min_match_reg);
    assign pready = 1'b1;

    cpm_ram #(
        .WIDTH (cpm_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    cpm_match u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (match_start),
        .win_start  (rd_start),
        .win_length (rd_length),
        .query_time (t_reg),
        .status     (mstat)
    );

    assign s_axis_tready = s_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_found_implies_success: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("prediction found without success");

    a_found_above_min: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[22:6] > min_match_reg)
        else $error("winning match not above minimum");

    a_done_only_in_match: assert property (
        @(posedge clk) disable iff (!rst_n)
        mstat.done |-> state_reg == cpm_pkg::ST_MATCH)
        else $error("match unit finished outside a match step");

    a_accept_leaves_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg != cpm_pkg::ST_IDLE)
        else $error("accepted word did not start work");

endmodule

// ===== test/tb.sv =====
// Self-checking bench for contact_prediction_matcher: loads prediction windows, validates
// query times against them and checks every result word against an in-bench predictor.
// Depends on rtl/cpm_pkg.sv and the block's RTL; needs nothing else.
`timescale 1ns / 1ps

module tb;
    import cpm_pkg::*;

    localparam int RING           = ENTRIES_DEFAULT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_TAIL       = 400;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 220;
    localparam int MAX_PRINTS     = 40;

    // Bit offsets of the input word fields
    localparam int OFF_COUNT = 4;
    localparam int OFF_QTIME = 9;
    localparam int OFF_START = 73;
    localparam int OFF_LEN   = 137;
    localparam int OFF_PROB  = 169;
    localparam int OFF_ELEV  = 185;

    localparam logic [APB_ADDR_W-1:0] ADDR_MIN_PROB  = {REG_MIN_PROB, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_MIN_MATCH = {REG_MIN_MATCH, 2'b00};

    typedef struct packed {
        logic               success;
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [MATCH_W-1:0] match_q16;
    } outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Predictor copy of the ring and the thresholds
    logic [TIME_W-1:0]  win_start [RING];
    logic [LEN_W-1:0]   win_len [RING];
    logic [PROB_W-1:0]  win_prob [RING];
    logic [PROB_W-1:0]  cfg_min_prob  = MIN_PROB_RESET;
    logic [MATCH_W-1:0] cfg_min_match = MIN_MATCH_RESET;

    outcome_t pending_results[$];

    int          errors       = 0;
    int          n_loads      = 0;
    int          n_queries    = 0;
    int          n_found      = 0;
    int          n_fallback   = 0;
    bit          idle_on      = 1'b1;
    bit          result_taken = 1'b0;
    int          hold_request = 0;
    logic [63:0] cluster_base = 64'd0;

    contact_prediction_matcher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_gap();
        if (!idle_on)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_word(
        input logic [SLOT_W-1:0]  slot,
        input logic [COUNT_W-1:0] count,
        input logic [TIME_W-1:0]  qtime,
        input logic [TIME_W-1:0]  wstart,
        input logic [LEN_W-1:0]   wlen,
        input logic [PROB_W-1:0]  wprob,
        input logic               elev
    );
        return {6'b0, elev, wprob, wlen, wstart, qtime, count, slot};
    endfunction

    // Q16 closeness of t to a window: 1.0 inside, linear fall-off over one window length
    function automatic logic [MATCH_W-1:0] window_match(
        input logic [TIME_W-1:0] ws,
        input logic [LEN_W-1:0]  len,
        input logic [TIME_W-1:0] t
    );
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] we;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] distance;
        sum = {1'b0, ws} + {33'd0, len};
        we  = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        if (we <= ws)
            return '0;
        if (t >= ws && t <= we)
            return Q16_ONE;
        dur      = we - ws;
        distance = (t < ws) ? (ws - t) : (t - we);
        if (distance >= dur)
            return '0;
        return MATCH_W'(((dur - distance) << FRAC_W) / dur);
    endfunction

    function automatic outcome_t predict_outcome(input logic cmd, input logic [IN_TDATA_W-1:0] w);
        outcome_t           r;
        logic [SLOT_W-1:0]  idx;
        logic [COUNT_W-1:0] cnt;
        logic [TIME_W-1:0]  t;
        logic [MATCH_W-1:0] m;
        r   = '0;
        idx = w[SLOT_W-1:0];
        cnt = w[OFF_COUNT +: COUNT_W];
        t   = w[OFF_QTIME +: TIME_W];
        if (cmd == CMD_LOAD)
        begin
            win_start[idx] = w[OFF_START +: TIME_W];
            win_len[idx]   = w[OFF_LEN +: LEN_W];
            win_prob[idx]  = w[OFF_PROB +: PROB_W];
            return r;
        end
        if (cnt > RING)
            cnt = COUNT_W'(RING);
        for (int c = 0; c < cnt; c++)
        begin
            if (win_prob[idx] >= cfg_min_prob)
            begin
                m = window_match(win_start[idx], win_len[idx], t);
                if (m > cfg_min_match)
                begin
                    r.success   = 1'b1;
                    r.found     = 1'b1;
                    r.slot      = idx;
                    r.match_q16 = m;
                    return r;
                end
                // a future window that is still far off ends the walk
                if (win_start[idx] > t && m < EARLY_STOP_LIMIT)
                    break;
            end
            idx = SLOT_W'((idx + 1) % RING);
        end
        r.success = w[OFF_ELEV];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t ns mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
        outcome_t want;
        result_taken = 1'b1;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result word", 0, word);
            return;
        end
        want = pending_results.pop_front();
        if (word[0] !== want.success)
            report_mismatch("success", want.success, word[0]);
        if (word[1] !== want.found)
            report_mismatch("prediction_found", want.found, word[1]);
        if (word[5:2] !== want.slot)
            report_mismatch("matched_slot", want.slot, word[5:2]);
        if (word[22:6] !== want.match_q16)
            report_mismatch("match_value", want.match_q16, word[22:6]);
    endtask

    // Monitor: check results, predict accepted words, track register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
            begin
                outcome_t o;
                o = predict_outcome(s_axis_tuser, s_axis_tdata);
                pending_results.push_back(o);
                if (s_axis_tuser == CMD_LOAD)
                    n_loads++;
                else
                begin
                    n_queries++;
                    if (o.found)
                        n_found++;
                    else
                        n_fallback++;
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_MIN_PROB)
                    cfg_min_prob = pwdata[PROB_W-1:0];
                else if (paddr == ADDR_MIN_MATCH)
                    cfg_min_match = pwdata[MATCH_W-1:0];
            end
        end
    end

    // Receiver: random wait per result, or a long hold when asked
    initial
    begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (result_taken)
            begin
                result_taken = 1'b0;
                stall_left   = draw_gap();
            end
            m_axis_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Offer one word; valid stays high on return so a zero gap keeps it asserted
    task automatic send_word(input logic cmd, input logic [IN_TDATA_W-1:0] word);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic send_load(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] ws,
                             input logic [LEN_W-1:0] wl, input logic [PROB_W-1:0] wp);
        send_word(CMD_LOAD, pack_word(slot, COUNT_W'($urandom), {$urandom, $urandom},
                                      ws, wl, wp, 1'($urandom)));
    endtask

    task automatic send_query(input logic [SLOT_W-1:0] slot, input logic [COUNT_W-1:0] count,
                              input logic [TIME_W-1:0] t, input logic elev);
        send_word(CMD_VALIDATE, pack_word(slot, count, t, {$urandom, $urandom}, $urandom,
                                          PROB_W'($urandom), elev));
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle
    task automatic drain_results(input int tail);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [PROB_W-1:0] prob, input logic [MATCH_W-1:0] mm);
        logic [APB_DATA_W-1:0] rd;
        drain_results(4);
        apb_access(1'b1, ADDR_MIN_PROB, APB_DATA_W'(prob), rd);
        apb_access(1'b1, ADDR_MIN_MATCH, APB_DATA_W'(mm), rd);
        apb_access(1'b0, ADDR_MIN_PROB, '0, rd);
        if (rd !== APB_DATA_W'(cfg_min_prob))
            report_mismatch("min_probability read-back", cfg_min_prob, rd);
        apb_access(1'b0, ADDR_MIN_MATCH, '0, rd);
        if (rd !== APB_DATA_W'(cfg_min_match))
            report_mismatch("min_match read-back", cfg_min_match, rd);
    endtask

    task automatic send_random_load();
        logic [TIME_W-1:0] ws;
        logic [LEN_W-1:0]  wl;
        logic [PROB_W-1:0] wp;
        int                near;
        case ($urandom_range(0, 9))
            0:       ws = {$urandom, $urandom};
            1:       ws = {TIME_W{1'b1}} - $urandom_range(0, 5000);
            2:       ws = TIME_W'($urandom_range(0, 5000));
            default: ws = cluster_base + $urandom_range(0, 200000);
        endcase
        case ($urandom_range(0, 7))
            0:       wl = '0;
            1:       wl = '1;
            2:       wl = $urandom;
            3:       wl = $urandom_range(1, 16);
            default: wl = $urandom_range(100, 20000);
        endcase
        case ($urandom_range(0, 4))
            0: wp = '1;
            1: wp = '0;
            2: wp = PROB_W'($urandom);
            default:
            begin
                // hover around the threshold so both sides of it are hit
                near = int'(cfg_min_prob) + $urandom_range(0, 8) - 4;
                if (near < 0)
                    near = 0;
                if (near > 65535)
                    near = 65535;
                wp = PROB_W'(near);
            end
        endcase
        send_load(SLOT_W'($urandom), ws, wl, wp);
    endtask

    task automatic send_random_query();
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
        logic [SLOT_W-1:0]  target;
        logic [TIME_W-1:0]  s;
        logic [TIME_W-1:0]  l;
        logic [TIME_W-1:0]  t;
        slot = SLOT_W'($urandom);
        case ($urandom_range(0, 5))
            0:       count = COUNT_W'($urandom);
            1:       count = COUNT_W'(RING);
            default: count = COUNT_W'($urandom_range(1, 8));
        endcase
        // aim at an entry that the walk will reach
        target = (count == 0) ? slot : SLOT_W'((slot + $urandom_range(0, count - 1)) % RING);
        s = win_start[target];
        l = {32'd0, win_len[target]};
        case ($urandom_range(0, 9))
            0: t = {$urandom, $urandom};
            1: t = s;
            2: t = s + l;
            3: t = s - $urandom_range(0, win_len[target]);
            4: t = s + l + $urandom_range(0, win_len[target]);
            5: t = s - l - $urandom_range(0, 100);
            6: t = cluster_base + $urandom_range(0, 200000);
            default: t = s + $urandom_range(0, win_len[target]);
        endcase
        send_query(slot, count, t, 1'($urandom));
    endtask

    task automatic send_random_item();
        if ($urandom_range(0, 9) < 3)
            send_random_load();
        else
            send_random_query();
    endtask

    // Fill the whole ring, then hit each corner of the walk and the match
    task automatic test_directed_windows();
        idle_on = 1'b0;
        send_load(4'd0, 64'd1000, 32'd100, 16'hFFFF);
        send_load(4'd1, 64'd0, 32'd0, 16'hFFFF);
        send_load(4'd2, {TIME_W{1'b1}}, 32'hFFFF_FFFF, 16'hFFFF);
        send_load(4'd3, {TIME_W{1'b1}} - 64'd200, 32'd1000, 16'hFFFF);
        send_load(4'd4, 64'd5000, 32'd1000, 16'd0);
        send_load(4'd5, 64'd5000, 32'd1000, MIN_PROB_RESET);
        send_load(4'd6, 64'd1_000_000, 32'd10, 16'hFFFF);
        send_load(4'd7, 64'd2000, 32'd400, 16'd40000);
        for (int i = 8; i < RING; i++)
            send_load(SLOT_W'(i), 64'(10000 * i), 32'(500 + i), 16'd50000);
        idle_on = 1'b1;
        send_query(4'd0, 5'd1, 64'd1050, 1'b0);
        send_query(4'd0, 5'd1, 64'd1000, 1'b0);
        send_query(4'd0, 5'd1, 64'd1100, 1'b0);
        send_query(4'd0, 5'd1, 64'd990, 1'b0);
        send_query(4'd0, 5'd1, 64'd1150, 1'b1);
        send_query(4'd0, 5'd0, 64'd1050, 1'b1);
        send_query(4'd1, 5'd1, 64'd0, 1'b0);
        send_query(4'd3, 5'd1, {TIME_W{1'b1}}, 1'b0);
        send_query(4'd4, 5'd2, 64'd5500, 1'b0);
        send_query(4'd6, 5'd2, 64'd2100, 1'b1);
        send_query(4'd4, 5'd31, {TIME_W{1'b1}}, 1'b0);
        drain_results(4);
    endtask

    // Hold the result side for a long stretch while words keep coming
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        @(posedge clk);
        hold_request = HOLD_CYCLES;
        repeat (12) send_random_item();
        drain_results(4);
        idle_on = 1'b1;
    endtask

    // Random traffic under several threshold settings; each change first drains the block
    task automatic test_threshold_sweep();
        logic [PROB_W-1:0]  probs [6];
        logic [MATCH_W-1:0] mms [6];
        probs = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, MIN_PROB_RESET};
        mms   = '{17'd0, Q16_ONE, Q16_ONE, 17'd0, 17'd0, MIN_MATCH_RESET};
        probs[4] = PROB_W'($urandom);
        mms[4]   = MATCH_W'($urandom_range(0, 65536));
        for (int p = 0; p < 6; p++)
        begin
            set_thresholds(probs[p], mms[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                begin
                    idle_on = ($urandom_range(0, 3) != 0);
                    case ($urandom_range(0, 4))
                        0:       cluster_base = 64'($urandom_range(0, 1000));
                        1:       cluster_base = {TIME_W{1'b1}} - 64'd300000;
                        default: cluster_base = {$urandom, $urandom};
                    endcase
                end
                send_random_item();
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = CMD_LOAD;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_windows();
        test_output_backpressure();
        test_threshold_sweep();

        drain_results(END_TAIL);
        $display("Ran %0d loads and %0d validates: %0d matched a window, %0d fell back",
                 n_loads, n_queries, n_found, n_fallback);
        $display("over six threshold settings, with a %0d-cycle output stall; %0d mismatches",
                 HOLD_CYCLES, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cpm_pkg.sv
rtl/cpm_ram.sv
rtl/cpm_frac_div.sv
rtl/cpm_match.sv
rtl/contact_prediction_matcher.sv
test/tb.sv
